>>> sv/arpc_pkg.sv
// Shared types and constants of the ARP address cache.
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int IP_W            = 32;
  localparam int MAC_W           = 48;
  localparam int SLOT_W          = 4;
  localparam int DEF_ENTRY_COUNT = 16;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = ((IP_W + MAC_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((1 + MAC_W + SLOT_W + 1 + 7) / 8) * 8;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_LEARN  = 1'b1
  } op_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

endpackage

>>> sv/arp_address_cache_core.sv
// Top level of the ARP address cache: stream ports, table and sequencer.
`timescale 1ns / 1ps

// The cache holds ENTRY_COUNT IPv4-to-MAC bindings and serves one request at a time.
// Each request scans the whole table through the single read port of the binding
// memory, one entry per cycle: the request is taken, every entry is read and compared
// once its registered read data returns, and the request then finishes by writing back
// and posting the result, waiting first if an earlier result has not yet been taken.
// The result sits in an output register, so a new request can start while the last
// result waits to be taken. After reset every entry is empty; no clearing pass runs.
// Lookups report the lowest matching valid entry. Learns refresh a matching entry,
// else fill the lowest empty one, else overwrite entry 0 and flag the eviction.

module arp_address_cache_core #(
  parameter int ENTRY_COUNT = arpc_pkg::DEF_ENTRY_COUNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [arpc_pkg::IN_DATA_W-1:0]  in_tdata,   // ip_addr[31:0], mac_addr[79:32]
  input  logic [0:0]                      in_tuser,   // opcode[0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [arpc_pkg::OUT_DATA_W-1:0] out_tdata   // hit[0], mac_out[48:1],
                                                      // slot[52:49], evicted[53], zero[55:54]
);
  import arpc_pkg::*;

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_valid;
  entry_t            rd_entry;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_entry;
  op_t               req_op;
  logic              res_hit;
  logic [MAC_W-1:0]  res_mac;
  logic [SLOT_W-1:0] res_slot;
  logic              res_evicted;

  assign req_op = op_t'(in_tuser[0]);

  arpc_table #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  arpc_ctrl #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_op      (req_op),
    .req_ip      (in_tdata[IP_W-1:0]),
    .req_mac     (in_tdata[IP_W+MAC_W-1:IP_W]),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_hit     (res_hit),
    .res_mac     (res_mac),
    .res_slot    (res_slot),
    .res_evicted (res_evicted),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_valid    (rd_valid),
    .rd_entry    (rd_entry),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_entry    (wr_entry)
  );

  assign out_tdata = {{(OUT_DATA_W - MAC_W - SLOT_W - 2){1'b0}},
                      res_evicted, res_slot, res_mac, res_hit};

endmodule

>>> sv/arpc_table.sv
// Binding store: valid flags in flip-flops, IP and MAC in a synchronous memory.
`timescale 1ns / 1ps

module arpc_table #(
  parameter int ENTRY_COUNT = arpc_pkg::DEF_ENTRY_COUNT,
  parameter int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic                rd_valid,
  output arpc_pkg::entry_t    rd_entry,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  arpc_pkg::entry_t    wr_entry
);
  import arpc_pkg::*;

  entry_t                 mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] valid_r;
  logic                   rd_valid_r;
  entry_t                 rd_entry_r;

  // The memory contents need no clearing: an entry is only used once its flag is set.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_entry = rd_entry_r;

`ifndef SYNTH
  // The scan and the write-back never share a cycle.
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("table read and write in the same cycle");

  a_written_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(wr_addr)])
    else $error("written entry not marked valid");
`endif

endmodule

>>> sv/arpc_ctrl.sv
// Request sequencer: scans the table, picks the slot, writes back and holds the result.
`timescale 1ns / 1ps

module arpc_ctrl #(
  parameter int ENTRY_COUNT = arpc_pkg::DEF_ENTRY_COUNT,
  parameter int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  arpc_pkg::op_t               req_op,
  input  logic [arpc_pkg::IP_W-1:0]   req_ip,
  input  logic [arpc_pkg::MAC_W-1:0]  req_mac,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic                        res_hit,
  output logic [arpc_pkg::MAC_W-1:0]  res_mac,
  output logic [arpc_pkg::SLOT_W-1:0] res_slot,
  output logic                        res_evicted,
  output logic                        rd_en,
  output logic [IDX_W-1:0]            rd_addr,
  input  logic                        rd_valid,
  input  arpc_pkg::entry_t            rd_entry,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_addr,
  output arpc_pkg::entry_t            wr_entry
);
  import arpc_pkg::*;

  localparam int CNT_W = $clog2(ENTRY_COUNT + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r;
  logic [IP_W-1:0]   ip_r;
  logic [MAC_W-1:0]  mac_r;
  logic [CNT_W-1:0]  scan_cnt_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              match_found_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [MAC_W-1:0]  match_mac_r;
  logic              empty_found_r;
  logic [IDX_W-1:0]  empty_idx_r;
  logic              out_valid_r;
  logic              out_hit_r;
  logic [MAC_W-1:0]  out_mac_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_evicted_r;

  logic              accept;
  logic              issuing;
  logic              scan_done;
  logic              hit_now;
  logic              empty_now;
  logic              finish_fire;
  logic              full;
  logic [IDX_W-1:0]  target_idx;
  logic [IDX_W-1:0]  res_idx;
  logic [IDX_W+SLOT_W-1:0] res_idx_ext;

  assign accept      = req_valid && req_ready;
  assign req_ready   = (state_r == ST_IDLE);
  assign issuing     = (state_r == ST_SCAN) && (scan_cnt_r < CNT_W'(ENTRY_COUNT));
  assign scan_done   = (state_r == ST_SCAN) && (scan_cnt_r == CNT_W'(ENTRY_COUNT));
  assign hit_now     = cmp_vld_r && rd_valid && (rd_entry.ip == ip_r);
  assign empty_now   = cmp_vld_r && !rd_valid;
  assign finish_fire = (state_r == ST_FINISH) && (!out_valid_r || res_ready);

  assign rd_en   = issuing;
  assign rd_addr = scan_cnt_r[IDX_W-1:0];

  // Learn target: matching entry, else lowest empty entry, else entry 0.
  assign full       = !match_found_r && !empty_found_r;
  assign target_idx = match_found_r ? match_idx_r :
                      (empty_found_r ? empty_idx_r : '0);

  assign wr_en        = finish_fire && (op_r == OP_LEARN);
  assign wr_addr      = target_idx;
  assign wr_entry.ip  = ip_r;
  assign wr_entry.mac = mac_r;

  assign res_idx     = (op_r == OP_LEARN) ? target_idx :
                       (match_found_r ? match_idx_r : '0);
  assign res_idx_ext = {{SLOT_W{1'b0}}, res_idx};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      scan_cnt_r    <= '0;
      cmp_vld_r     <= 1'b0;
      match_found_r <= 1'b0;
      empty_found_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= issuing;
      if (accept) begin
        scan_cnt_r    <= '0;
        match_found_r <= 1'b0;
        empty_found_r <= 1'b0;
      end else begin
        if (issuing) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        if (hit_now) begin
          match_found_r <= 1'b1;
        end
        if (empty_now) begin
          empty_found_r <= 1'b1;
        end
      end
      if (finish_fire) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= req_op;
      ip_r  <= req_ip;
      mac_r <= req_mac;
    end
    if (issuing) begin
      cmp_idx_r <= scan_cnt_r[IDX_W-1:0];
    end
    // Only the first match and the first empty entry are kept.
    if (hit_now && !match_found_r) begin
      match_idx_r <= cmp_idx_r;
      match_mac_r <= rd_entry.mac;
    end
    if (empty_now && !empty_found_r) begin
      empty_idx_r <= cmp_idx_r;
    end
    if (finish_fire) begin
      out_hit_r     <= match_found_r;
      out_mac_r     <= ((op_r == OP_LOOKUP) && match_found_r) ? match_mac_r : '0;
      out_slot_r    <= res_idx_ext[SLOT_W-1:0];
      out_evicted_r <= (op_r == OP_LEARN) && full;
    end
  end

  assign res_valid   = out_valid_r;
  assign res_hit     = out_hit_r;
  assign res_mac     = out_mac_r;
  assign res_slot    = out_slot_r;
  assign res_evicted = out_evicted_r;

`ifndef SYNTH
  a_evict_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evicted_r) |-> (!out_hit_r && (out_slot_r == '0)))
    else $error("eviction reported with a hit or a nonzero slot");

  a_mac_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_mac_r != '0)) |-> (out_hit_r && !out_evicted_r))
    else $error("MAC reported without a lookup hit");

  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    finish_fire |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished request did not produce a result");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_cnt_r <= CNT_W'(ENTRY_COUNT)))
    else $error("scan counter ran past the table");
`endif

endmodule
